>>> sv/skt_pkg.sv
package skt_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KEY_W  = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WALK,
    S_INS_PUT,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

>>> sv/sorted_key_table.sv
// out_valid rises once any walk over the key memory is done; the walk reads
// one entry per cycle through the memory's single read port
// throughput: one word at a time; a new word is taken as soon as the previous
// result is handed to the output register, even while that result waits
// reset (rst, synchronous, active high) empties the table and drops any result;
// the key memory itself is not cleared, stale entries are never read
module sorted_key_table
  import skt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              opcode,
  input  logic signed [KEY_W-1:0] key,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic [4:0]              entry_count,
  output logic                    is_empty
);

  logic signed [KEY_W-1:0] mem [DEPTH];
  logic signed [KEY_W-1:0] rdata;

  state_t state, state_next;

  logic [1:0]              op;
  logic signed [KEY_W-1:0] key_r;
  logic [CNT_W-1:0]        count, count_next;
  logic [1:0]              st, st_next;
  logic [ADDR_W-1:0]       ra, ra_next;

  logic                    we;
  logic [ADDR_W-1:0]       wa;
  logic signed [KEY_W-1:0] wd;
  logic [ADDR_W-1:0]       raddr;

  logic              accept;
  logic              out_free;
  logic [CNT_W-1:0]  last;
  logic              at_last;
  logic              below;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign last     = CNT_W'(count - 1'b1);
  assign at_last  = CNT_W'(ra) == last;
  assign below    = rdata < key_r;
  assign in_ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_INSERT: begin
              if (count >= CNT_W'(DEPTH) || count == '0) state_next = S_DONE;
              else state_next = S_INS_WALK;
            end
            OP_SEARCH, OP_REMOVE: begin
              if (count == '0) state_next = S_DONE;
              else state_next = S_SCAN;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_INS_WALK: begin
        if (below) state_next = S_DONE;
        else if (ra == '0) state_next = S_INS_PUT;
      end
      S_INS_PUT: state_next = S_DONE;
      S_SCAN: begin
        if (below) begin
          if (at_last) state_next = S_DONE;
        end else if (rdata == key_r && op == OP_REMOVE && !at_last) begin
          state_next = S_SHIFT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        if (at_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory control and result bookkeeping
  always_comb begin
    we         = 1'b0;
    wa         = ra;
    wd         = rdata;
    raddr      = ra;
    ra_next    = ra;
    count_next = count;
    st_next    = st;
    case (state)
      S_IDLE: begin
        if (accept) begin
          st_next = ST_MISSING;
          case (opcode)
            OP_INSERT: begin
              if (count >= CNT_W'(DEPTH)) begin
                st_next = ST_FULL;
              end else if (count == '0) begin
                we         = 1'b1;
                wa         = '0;
                wd         = key;
                count_next = CNT_W'(1);
                st_next    = ST_OK;
              end else begin
                raddr   = ADDR_W'(last);
                ra_next = ADDR_W'(last);
              end
            end
            OP_SEARCH, OP_REMOVE: begin
              raddr   = '0;
              ra_next = '0;
            end
            default: ;
          endcase
        end
      end
      S_INS_WALK: begin
        // entries not below the key move up one place, walking down from the top
        we = 1'b1;
        wa = ADDR_W'(ra + 1'b1);
        if (below) begin
          wd         = key_r;
          count_next = CNT_W'(count + 1'b1);
          st_next    = ST_OK;
        end else begin
          raddr   = ADDR_W'(ra - 1'b1);
          ra_next = ADDR_W'(ra - 1'b1);
        end
      end
      S_INS_PUT: begin
        we         = 1'b1;
        wa         = '0;
        wd         = key_r;
        count_next = CNT_W'(count + 1'b1);
        st_next    = ST_OK;
      end
      S_SCAN: begin
        raddr   = ADDR_W'(ra + 1'b1);
        ra_next = ADDR_W'(ra + 1'b1);
        if (!below && rdata == key_r) begin
          st_next = ST_OK;
          if (op == OP_REMOVE && at_last) count_next = last;
        end
      end
      S_SHIFT: begin
        // close the gap: entry ra moves down to ra-1
        we      = 1'b1;
        wa      = ADDR_W'(ra - 1'b1);
        raddr   = ADDR_W'(ra + 1'b1);
        ra_next = ADDR_W'(ra + 1'b1);
        if (at_last) count_next = last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    ra <= ra_next;
    st <= st_next;
    if (accept) begin
      op    <= opcode;
      key_r <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status      <= st;
      entry_count <= 5'(count);
      is_empty    <= (count == '0);
    end
  end

endmodule

>>> sv/skt_checker.sv
module skt_checker
  import skt_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [1:0]              opcode,
  input logic signed [KEY_W-1:0] key,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [1:0]              status,
  input logic [4:0]              entry_count,
  input logic                    is_empty
);

  // empty flag agrees with the count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (entry_count == 5'd0)))
    else $error("is_empty disagrees with entry_count");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_MISSING || status == ST_FULL))
    else $error("undefined status code");

  // a refused insert only happens on a full table
  a_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (entry_count == 5'(DEPTH)))
    else $error("full reported below capacity");

  // a refused insert never comes with the empty flag set
  a_empty_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> !is_empty)
    else $error("full reported on empty table");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(entry_count)))
    else $error("result word changed while stalled");

endmodule

bind sorted_key_table skt_checker u_skt_checker (.*);

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb
  import skt_pkg::*;
();

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;
  localparam logic signed [KEY_W-1:0] KEY_SENTINEL = -32'sd999;
  localparam int WORD_TARGET = 1150;
  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD = 400;
  localparam int POOL_N = 10;

  typedef struct {
    bit                      pause;
    logic [1:0]              opcode;
    logic signed [KEY_W-1:0] key;
  } table_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] entry_count;
    logic       is_empty;
  } table_result_t;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_NOISE} mix_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              opcode = OP_INSERT;
  logic signed [KEY_W-1:0] key = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [1:0]              status;
  logic [4:0]              entry_count;
  logic                    is_empty;

  sorted_key_table dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .key        (key),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .entry_count(entry_count),
    .is_empty   (is_empty)
  );

  table_word_t             pending_words[$];
  table_result_t           results_due[$];
  logic signed [KEY_W-1:0] shadow_keys[$];
  int                      errors = 0;
  int                      words_taken = 0;
  int                      gap_left = 0;
  int                      burst_left = 0;
  int                      hold_left = 0;
  bit                      long_hold_done = 1'b0;
  int                      stall_mode = 0;
  int                      mode_left = 0;
  int                      quiet_cycles = 0;

  // ascending shadow of the table, new key ahead of equal ones
  function automatic table_result_t apply_table_op(logic [1:0] op,
                                                   logic signed [KEY_W-1:0] k);
    table_result_t r;
    int pos;
    r.status = ST_MISSING;
    pos = 0;
    while (pos < shadow_keys.size() && shadow_keys[pos] < k) pos++;
    case (op)
      OP_INSERT: begin
        if (shadow_keys.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_keys.insert(pos, k);
          r.status = ST_OK;
        end
      end
      OP_SEARCH: begin
        if (pos < shadow_keys.size() && shadow_keys[pos] == k) r.status = ST_OK;
      end
      OP_REMOVE: begin
        if (pos < shadow_keys.size() && shadow_keys[pos] == k) begin
          shadow_keys.delete(pos);
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.entry_count = 5'(shadow_keys.size());
    r.is_empty = (shadow_keys.size() == 0);
    return r;
  endfunction

  function automatic void add_word(logic [1:0] op, logic signed [KEY_W-1:0] k);
    table_word_t w;
    w.pause = 1'b0;
    w.opcode = op;
    w.key = k;
    pending_words.push_back(w);
  endfunction

  function automatic void add_pause();
    table_word_t w;
    w.pause = 1'b1;
    w.opcode = OP_SEARCH;
    w.key = '0;
    pending_words.push_back(w);
  endfunction

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // sender: bursts of words with random gaps, pause markers wait for a drain
  always @(posedge clk) begin : drive
    bit offer;
    table_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      offer = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        results_due.push_back(apply_table_op(opcode, key));
        words_taken <= words_taken + 1;
      end
      if (!offer) begin
        if (pending_words.size() > 0 && pending_words[0].pause) begin
          if (results_due.size() == 0) void'(pending_words.pop_front());
        end else if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          offer = 1'b1;
          opcode <= w.opcode;
          key <= w.key;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
      in_valid <= offer;
    end
  end

  // receiver: the stall pattern is redrawn when its random run ends, one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      mode_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!long_hold_done && words_taken >= 300) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin : check
    table_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("result word with nothing expected: status %0d count %0d empty %0d",
               status, entry_count, is_empty);
        errors++;
      end else begin
        exp_r = results_due.pop_front();
        if (status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status);
          errors++;
        end
        if (entry_count !== exp_r.entry_count) begin
          $error("entry_count: expected %0d, got %0d", exp_r.entry_count, entry_count);
          errors++;
        end
        if (is_empty !== exp_r.is_empty) begin
          $error("is_empty: expected %0d, got %0d", exp_r.is_empty, is_empty);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL sorted_key_table");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic signed [KEY_W-1:0] key_pool[POOL_N];
    logic signed [KEY_W-1:0] k;
    logic [1:0]              op;
    mix_t                    mix;
    int                      total;
    int                      phase_len;
    int                      roll;
    bit                      mid_pause;

    // empty table, unused opcode, extremes, duplicates, removal down to empty
    add_word(OP_SEARCH, '0);
    add_word(OP_REMOVE, 32'sd5);
    add_word(OP_UNUSED, 32'shffff_ffff);
    add_word(OP_INSERT, KEY_MAX);
    add_word(OP_INSERT, KEY_MIN);
    add_word(OP_INSERT, -32'sd1);
    add_word(OP_INSERT, '0);
    add_word(OP_INSERT, '0);
    add_word(OP_INSERT, KEY_SENTINEL);
    add_word(OP_SEARCH, KEY_SENTINEL);
    add_word(OP_SEARCH, KEY_MIN);
    add_word(OP_SEARCH, KEY_MAX);
    add_word(OP_SEARCH, 32'sd1);
    add_word(OP_UNUSED, '0);
    add_word(OP_REMOVE, '0);
    add_word(OP_REMOVE, '0);
    add_word(OP_REMOVE, '0);
    add_word(OP_REMOVE, KEY_MAX);
    add_word(OP_REMOVE, KEY_MIN);
    add_word(OP_REMOVE, -32'sd1);
    add_word(OP_REMOVE, KEY_SENTINEL);
    add_pause();
    total = 21;

    // fill past full with random keys, then remove the keys still held in the pool
    for (int i = 0; i < 18; i++) begin
      k = (i % 3 == 0) ? 32'sd7 : $urandom();
      add_word(OP_INSERT, k);
      key_pool[i % POOL_N] = k;
    end
    for (int i = 0; i < 18; i++) add_word(OP_REMOVE, key_pool[i % POOL_N]);
    total += 36;

    mid_pause = 1'b0;
    while (total < WORD_TARGET) begin
      for (int i = 0; i < POOL_N; i++) begin
        roll = $urandom_range(0, 9);
        if (roll < 4) key_pool[i] = $signed(32'($urandom_range(0, 20))) - 32'sd10;
        else if (roll < 8) key_pool[i] = $urandom();
        else if (roll == 8) key_pool[i] = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
        else key_pool[i] = KEY_SENTINEL;
      end
      mix = mix_t'($urandom_range(0, 2));
      phase_len = $urandom_range(20, 80);
      for (int i = 0; i < phase_len; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          op = OP_UNUSED;
        end else begin
          case (mix)
            MIX_FILL:  op = (roll < 77) ? OP_INSERT : (roll < 90) ? OP_SEARCH : OP_REMOVE;
            MIX_DRAIN: op = (roll < 75) ? OP_REMOVE : (roll < 88) ? OP_SEARCH : OP_INSERT;
            default:   op = 2'($urandom_range(0, 2));
          endcase
        end
        k = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, POOL_N - 1)]
                                       : $urandom();
        add_word(op, k);
        total++;
      end
      if (!mid_pause && total >= WORD_TARGET / 2) begin
        add_pause();
        mid_pause = 1'b1;
      end
    end

    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || results_due.size() != 0);
    repeat (DEPTH + 8) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("%0d result words never arrived", results_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS sorted_key_table");
    end else begin
      $display("FAIL sorted_key_table");
    end
    $finish;
  end

endmodule
